@@ hw/rtl/dtwpb_pkg.sv @@
// Shared types, constants and helpers for the DTW path backtrace block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dtwpb_pkg;

   localparam int MAX_DIM    = 64;
   localparam int COST_BITS  = 32;
   localparam int DIM_BITS   = $clog2(MAX_DIM);
   localparam int COST_DEPTH = MAX_DIM * MAX_DIM;
   localparam int COST_ABITS = 2 * DIM_BITS;
   localparam int PATH_DEPTH = 2 * MAX_DIM;
   localparam int PATH_BITS  = $clog2(PATH_DEPTH);

   // request / response field widths
   localparam int OP_W    = 2;
   localparam int POS_W   = 7;
   localparam int CFG_W   = 7;
   localparam int IDX_W   = 7;
   localparam int STAT_W  = 2;
   localparam int PT_W    = 6;
   localparam int LEN_W   = 7;
   localparam int REQ_DW  = 56;
   localparam int RSP_DW  = 24;

   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_TRACE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_START = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_BAD_ADDR  = 2'd3
   } status_type;

   typedef enum logic {
      REG_N_ROWS = 1'b0,
      REG_N_COLS = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic                 en;
      logic [DIM_BITS-1:0]  row;
      logic [DIM_BITS-1:0]  col;
      logic [COST_BITS-1:0] data;
   } cost_wr_type;

   typedef struct packed {
      logic                 en;
      logic [PATH_BITS-1:0] idx;
      logic [DIM_BITS-1:0]  row;
      logic [DIM_BITS-1:0]  col;
   } path_wr_type;

   typedef struct packed {
      logic                 done;
      logic [PATH_BITS-1:0] count;
   } trace_done_type;

   // size in use: zero acts as one, anything above MAX_DIM as MAX_DIM
   function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
      logic [CFG_W-1:0] d;
      if (r == '0) begin
         d = CFG_W'(1);
      end else if (r > DIM_RESET) begin
         d = DIM_RESET;
      end else begin
         d = r;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dtwpb_csr.sv @@
// Configuration registers (n_rows, n_cols) behind an APB-style port.
// Depends on dtwpb_pkg.
`default_nettype none

module dtwpb_csr
   import dtwpb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output logic      [CFG_W-1:0] n_rows,
   output logic      [CFG_W-1:0] n_cols
);

   logic [CFG_W-1:0] n_rows_ff, n_rows_in;
   logic [CFG_W-1:0] n_cols_ff, n_cols_in;
   logic             wr_en;
   reg_idx_type      sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sel        = reg_idx_type'(csr_paddr[2]);

   always_comb begin
      n_rows_in = n_rows_ff;
      n_cols_in = n_cols_ff;
      if (wr_en) begin
         unique case (sel)
            REG_N_ROWS: n_rows_in = csr_pwdata[CFG_W-1:0];
            REG_N_COLS: n_cols_in = csr_pwdata[CFG_W-1:0];
            default:    n_rows_in = n_rows_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_N_ROWS: csr_prdata = {{(32-CFG_W){1'b0}}, n_rows_ff};
         REG_N_COLS: csr_prdata = {{(32-CFG_W){1'b0}}, n_cols_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_rows_ff <= DIM_RESET;
         n_cols_ff <= DIM_RESET;
      end else begin
         n_rows_ff <= n_rows_in;
         n_cols_ff <= n_cols_in;
      end
   end

   assign n_rows = n_rows_ff;
   assign n_cols = n_cols_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dtwpb_tracer.sv @@
// Cost matrix memory and the backtrace walker: one read port, one shared
// compare unit, stepped by a small sequencer. Depends on dtwpb_pkg.
`default_nettype none

module dtwpb_tracer
   import dtwpb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cost_wr_type         cost_wr,
   input  wire logic                start,
   input  wire logic [DIM_BITS-1:0] start_row,
   input  wire logic [DIM_BITS-1:0] start_col,
   output path_wr_type              path_wr,
   output trace_done_type           trace_done
);

   typedef enum logic [5:0] {
      W_IDLE   = 6'b000001,
      W_STORE  = 6'b000010,
      W_RD_DG  = 6'b000100,
      W_RD_LF  = 6'b001000,
      W_RD_UP  = 6'b010000,
      W_CMP_UP = 6'b100000
   } walk_state_type;

   typedef enum logic [1:0] {
      MV_DIAG = 2'd0,
      MV_LEFT = 2'd1,
      MV_UP   = 2'd2
   } move_type;

   logic [COST_BITS-1:0] cost_mem [COST_DEPTH];
   logic [COST_BITS-1:0] rdata_ff;
   logic [COST_ABITS-1:0] rd_addr;

   walk_state_type       state_ff, state_in;
   logic [DIM_BITS-1:0]  i_ff, i_in, j_ff, j_in;
   logic [DIM_BITS-1:0]  i_m1, j_m1;
   logic [PATH_BITS-1:0] k_ff, k_in;
   logic [COST_BITS-1:0] best_ff, best_in;
   move_type             dir_ff, dir_in, dir_fin;
   logic                 cmp_lt;

   assign i_m1   = i_ff - DIM_BITS'(1);
   assign j_m1   = j_ff - DIM_BITS'(1);
   // the one comparator, reused for the left and up neighbors
   assign cmp_lt = rdata_ff < best_ff;

   always_ff @(posedge clock) begin
      if (cost_wr.en) begin
         cost_mem[{cost_wr.row, cost_wr.col}] <= cost_wr.data;
      end
      rdata_ff <= cost_mem[rd_addr];
   end

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      best_in    = best_ff;
      dir_in     = dir_ff;
      dir_fin    = dir_ff;
      rd_addr    = {i_m1, j_m1};
      path_wr    = '{en: 1'b0, idx: k_ff, row: i_ff, col: j_ff};
      trace_done = '{done: 1'b0, count: k_ff + PATH_BITS'(1)};
      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               i_in     = start_row;
               j_in     = start_col;
               k_in     = '0;
               state_in = W_STORE;
            end
         end
         W_STORE: begin
            // path kept backward; the reader flips the index
            path_wr.en = 1'b1;
            k_in       = k_ff + PATH_BITS'(1);
            if (i_ff == '0 && j_ff == '0) begin
               trace_done.done = 1'b1;
               state_in        = W_IDLE;
            end else if (i_ff == '0) begin
               j_in = j_m1;
            end else if (j_ff == '0) begin
               i_in = i_m1;
            end else begin
               state_in = W_RD_DG;
            end
         end
         W_RD_DG: begin
            rd_addr  = {i_m1, j_m1};
            state_in = W_RD_LF;
         end
         W_RD_LF: begin
            // diagonal cost is back from the memory
            rd_addr  = {i_ff, j_m1};
            best_in  = rdata_ff;
            dir_in   = MV_DIAG;
            state_in = W_RD_UP;
         end
         W_RD_UP: begin
            rd_addr  = {i_m1, j_ff};
            if (cmp_lt) begin
               best_in = rdata_ff;
               dir_in  = MV_LEFT;
            end
            state_in = W_CMP_UP;
         end
         W_CMP_UP: begin
            dir_fin = cmp_lt ? MV_UP : dir_ff;
            case (dir_fin)
               MV_DIAG: begin
                  i_in = i_m1;
                  j_in = j_m1;
               end
               MV_LEFT: j_in = j_m1;
               default: i_in = i_m1;
            endcase
            state_in = W_STORE;
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      best_ff <= best_in;
      dir_ff  <= dir_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/dtw_path_backtrace.sv @@
// DTW path backtrace top level: request decode, path store, response register.
// Depends on dtwpb_pkg, dtwpb_csr and dtwpb_tracer.
//
// Usage:
//  - Requests arrive on req_* (operation in req_tuser). A write loads one
//    cost entry, a trace walks from a start cell back to (0,0) and stores
//    the path, a read returns one path point in forward order.
//  - Each request gives exactly one response on rsp_* (status in rsp_tuser).
//  - Writes, rejected requests and unused codes answer in the cycle after
//    acceptance; a point read first reads the path store, then answers.
//  - A trace stores one path point per step, and each interior step adds
//    three reads through the single cost memory port feeding one shared
//    comparator.
//  - One request at a time: req_tready is low while a request is in work,
//    and also while a response waits that is not taken in that cycle.
//  - A stalled receiver holds the response in the output register.
//  - Reset clears the control state and path length and sets both sizes
//    to 64; cost entries and path points are undefined until written.
//  - csr_* is an APB-style port: n_rows at 0x0, n_cols at 0x4.
`default_nettype none

module dtw_path_backtrace
   import dtwpb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [6:0] row, [13:7] col, [45:14] cost_value, [52:46] point_index, rest zero
   input  wire logic [REQ_DW-1:0] req_tdata,
   // [1:0] operation
   input  wire logic [OP_W-1:0]   req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [5:0] path_row, [11:6] path_col, [18:12] path_length, rest zero
   output logic      [RSP_DW-1:0] rsp_tdata,
   // [1:0] status
   output logic      [STAT_W-1:0] rsp_tuser,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic      [31:0]       csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [2:0] {
      T_IDLE  = 3'b001,
      T_READ  = 3'b010,
      T_TRACE = 3'b100
   } top_state_type;

   top_state_type         state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [PT_W-1:0]       rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [PATH_BITS-1:0]  path_count_ff, path_count_in;

   logic [CFG_W-1:0]      n_rows, n_cols, nr, nc;
   logic                  accept;
   op_type                op;
   logic [POS_W-1:0]      req_row, req_col;
   logic [COST_BITS-1:0]  req_cost;
   logic [IDX_W-1:0]      req_idx;
   logic                  row_neg, col_neg, row_oob, col_oob;
   logic [CFG_W-1:0]      row_start, col_start;

   cost_wr_type           cost_wr;
   logic                  start;
   path_wr_type           path_wr;
   trace_done_type        trace_done;

   logic [2*DIM_BITS-1:0] path_mem [PATH_DEPTH];
   logic [2*DIM_BITS-1:0] path_rdata_ff;
   logic [PATH_BITS-1:0]  path_raddr;

   dtwpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .n_rows      (n_rows),
      .n_cols      (n_cols)
   );

   dtwpb_tracer u_tracer (
      .clock      (clock),
      .reset      (reset),
      .cost_wr    (cost_wr),
      .start      (start),
      .start_row  (row_start[DIM_BITS-1:0]),
      .start_col  (col_start[DIM_BITS-1:0]),
      .path_wr    (path_wr),
      .trace_done (trace_done)
   );

   assign nr = eff_dim(n_rows);
   assign nc = eff_dim(n_cols);

   assign req_tready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign op       = op_type'(req_tuser);
   assign req_row  = req_tdata[6:0];
   assign req_col  = req_tdata[13:7];
   assign req_cost = req_tdata[45:14];
   assign req_idx  = req_tdata[52:46];

   assign row_neg   = req_row[POS_W-1];
   assign col_neg   = req_col[POS_W-1];
   assign row_oob   = !row_neg && (req_row >= nr);
   assign col_oob   = !col_neg && (req_col >= nc);
   // negative start means the last row / column
   assign row_start = row_neg ? (nr - CFG_W'(1)) : req_row;
   assign col_start = col_neg ? (nc - CFG_W'(1)) : req_col;

   // path held backward, so forward index idx sits at count-1-idx
   assign path_raddr = path_count_ff - PATH_BITS'(1) - req_idx[PATH_BITS-1:0];

   always_ff @(posedge clock) begin
      if (path_wr.en) begin
         path_mem[path_wr.idx] <= {path_wr.row, path_wr.col};
      end
      path_rdata_ff <= path_mem[path_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      path_count_in = path_count_ff;
      start         = 1'b0;
      cost_wr       = '{en: 1'b0, row: req_row[DIM_BITS-1:0],
                        col: req_col[DIM_BITS-1:0], data: req_cost};
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               rsp_status_in = ST_OK;
               rsp_row_in    = '0;
               rsp_col_in    = '0;
               case (op)
                  OP_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (row_neg || col_neg || row_oob || col_oob) begin
                        rsp_status_in = ST_BAD_ADDR;
                     end else begin
                        cost_wr.en = 1'b1;
                     end
                  end
                  OP_TRACE: begin
                     if (row_oob || col_oob) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_START;
                     end else begin
                        start    = 1'b1;
                        state_in = T_TRACE;
                     end
                  end
                  OP_READ: begin
                     if (req_idx >= IDX_W'(path_count_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_INDEX;
                     end else begin
                        state_in = T_READ;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         T_READ: begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = PT_W'(path_rdata_ff[2*DIM_BITS-1:DIM_BITS]);
            rsp_col_in   = PT_W'(path_rdata_ff[DIM_BITS-1:0]);
            state_in     = T_IDLE;
         end
         T_TRACE: begin
            if (trace_done.done) begin
               rsp_valid_in  = 1'b1;
               path_count_in = trace_done.count;
               state_in      = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         rsp_valid_ff  <= 1'b0;
         path_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         path_count_ff <= path_count_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DW-PT_W-PT_W-LEN_W){1'b0}},
                        LEN_W'(path_count_ff), rsp_col_ff, rsp_row_ff};

endmodule

`default_nettype wire

@@ verif/dtw_path_backtrace_tb.sv @@
// Self-checking testbench for dtw_path_backtrace: cost loads, path traces and
// point reads on the request stream, checked against an in-bench path model.
// Depends on dtwpb_pkg and the dtw_path_backtrace RTL.
module dtw_path_backtrace_tb
   import dtwpb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 380;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_CAP   = 100;

   typedef enum int {FILL_RANDOM, FILL_TIES, FILL_SKEW} fill_kind_type;
   typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_SPARSE} stall_kind_type;

   typedef struct {
      status_type       status;
      logic [PT_W-1:0]  prow;
      logic [PT_W-1:0]  pcol;
      logic [LEN_W-1:0] plen;
   } path_rsp_type;

   class path_scoreboard;
      logic [COST_BITS-1:0] cost_mem [COST_DEPTH];
      logic [PT_W-1:0]      point_row [PATH_DEPTH];
      logic [PT_W-1:0]      point_col [PATH_DEPTH];
      int                   path_len;
      logic [CFG_W-1:0]     rows_reg;
      logic [CFG_W-1:0]     cols_reg;
      path_rsp_type         expected_q [$];
      int                   errors;

      function new();
         rows_reg = CFG_W'(MAX_DIM);
         cols_reg = CFG_W'(MAX_DIM);
         path_len = 0;
         errors   = 0;
      endfunction

      function int clamp_size(logic [CFG_W-1:0] r);
         if (r == '0) return 1;
         if (int'(r) > MAX_DIM) return MAX_DIM;
         return int'(r);
      endfunction

      function int rows_in_use();
         return clamp_size(rows_reg);
      endfunction

      function int cols_in_use();
         return clamp_size(cols_reg);
      endfunction

      function void set_reg(reg_idx_type which, logic [CFG_W-1:0] value);
         if (which == REG_N_ROWS) rows_reg = value;
         else cols_reg = value;
      endfunction

      // walk back to (0,0); ties prefer diagonal, then left, then up
      function void walk_path(int r0, int c0);
         int i, j, k;
         logic [COST_BITS-1:0] up, dg, lf;
         int rq [$];
         int cq [$];
         i = r0;
         j = c0;
         rq.push_front(i);
         cq.push_front(j);
         while (i > 0 || j > 0) begin
            if (i == 0) begin
               j--;
            end else if (j == 0) begin
               i--;
            end else begin
               up = cost_mem[(i - 1) * MAX_DIM + j];
               dg = cost_mem[(i - 1) * MAX_DIM + j - 1];
               lf = cost_mem[i * MAX_DIM + j - 1];
               if (dg <= up && dg <= lf) begin
                  i--;
                  j--;
               end else if (lf <= up) begin
                  j--;
               end else begin
                  i--;
               end
            end
            rq.push_front(i);
            cq.push_front(j);
         end
         for (k = 0; k < rq.size(); k++) begin
            point_row[k] = PT_W'(rq[k]);
            point_col[k] = PT_W'(cq[k]);
         end
         path_len = rq.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic signed [POS_W-1:0] row,
                                 logic signed [POS_W-1:0] col,
                                 logic [COST_BITS-1:0] cost, logic [IDX_W-1:0] idx);
         path_rsp_type e;
         int nr, nc, r, c;
         nr = rows_in_use();
         nc = cols_in_use();
         r  = int'(row);
         c  = int'(col);
         e.status = ST_OK;
         e.prow   = '0;
         e.pcol   = '0;
         case (op)
            OP_WRITE: begin
               if (r < 0 || c < 0 || r >= nr || c >= nc) e.status = ST_BAD_ADDR;
               else cost_mem[r * MAX_DIM + c] = cost;
            end
            OP_TRACE: begin
               if (r >= nr || c >= nc) e.status = ST_BAD_START;
               else walk_path(r < 0 ? nr - 1 : r, c < 0 ? nc - 1 : c);
            end
            OP_READ: begin
               if (int'(idx) >= path_len) begin
                  e.status = ST_BAD_INDEX;
               end else begin
                  e.prow = point_row[idx];
                  e.pcol = point_col[idx];
               end
            end
            default: ;
         endcase
         e.plen = LEN_W'(path_len);
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            // keep the log readable when the block is badly off
            if (errors <= REPORT_CAP)
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, name, exp_v, act_v);
         end
      endfunction

      function void check_response(logic [STAT_W-1:0] st, logic [PT_W-1:0] pr,
                                   logic [PT_W-1:0] pc, logic [LEN_W-1:0] len);
         path_rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: response with none expected, expected none, actual status %0d",
                        $time, st);
            return;
         end
         e = expected_q.pop_front();
         compare_field("status", 32'(e.status), 32'(st));
         compare_field("path_row", 32'(e.prow), 32'(pr));
         compare_field("path_col", 32'(e.pcol), 32'(pc));
         compare_field("path_length", 32'(e.plen), 32'(len));
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata   = '0;
   logic [OP_W-1:0]   req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [2:0]        csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   path_scoreboard sb = new();

   logic           offering     = 1'b0;
   int             burst_left   = 0;
   int             random_total = 0;
   logic           hold_toggle  = 1'b0;
   logic           hold_seen    = 1'b0;
   int             hold_left    = 0;
   int             pat_left     = 0;
   stall_kind_type pat_mode     = READY_ALWAYS;
   int             quiet_cycles = 0;

   dtw_path_backtrace dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver: changing ready patterns, plus one long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_mode <= stall_kind_type'($urandom_range(0, 3));
            pat_left <= int'($urandom_range(16, 96));
         end else begin
            pat_left <= pat_left - 1;
         end
         case (pat_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
            default:      rsp_tready <= (pat_left % 8 == 0);
         endcase
      end
   end

   // response check and no-progress watchdog
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[PT_W-1:0], rsp_tdata[2*PT_W-1:PT_W],
                           rsp_tdata[2*PT_W+LEN_W-1:2*PT_W]);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic stop_offer();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic pace();
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         stop_offer();
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(30, 80))
                                                  : int'($urandom_range(1, 12));
      end
   endtask

   task automatic send_req(logic [OP_W-1:0] op, logic signed [POS_W-1:0] row,
                           logic signed [POS_W-1:0] col, logic [COST_BITS-1:0] cost,
                           logic [IDX_W-1:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DW'({idx, cost, col, row});
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, row, col, cost, idx);
      pace();
   endtask

   task automatic wait_drain();
      stop_offer();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type which, logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= {25'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(which, value);
   endtask

   task automatic set_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
      wait_drain();
      write_reg(REG_N_ROWS, rows);
      write_reg(REG_N_COLS, cols);
   endtask

   function automatic logic [COST_BITS-1:0] cost_for(fill_kind_type kind, int r, int c);
      case (kind)
         FILL_TIES: return COST_BITS'($urandom_range(0, 3));
         // falls toward the far corner: left and up always beat the diagonal
         FILL_SKEW: return '1 - COST_BITS'(r + c);
         default:   return COST_BITS'($urandom);
      endcase
   endfunction

   task automatic fill_rect(fill_kind_type kind, int first_row);
      int r, c, nr, nc;
      nr = sb.rows_in_use();
      nc = sb.cols_in_use();
      for (r = first_row; r < nr; r++)
         for (c = 0; c < nc; c++)
            send_req(OP_WRITE, POS_W'(r), POS_W'(c), cost_for(kind, r, c),
                     IDX_W'($urandom));
   endtask

   task automatic random_item(fill_kind_type kind);
      int nr, nc, pick, r, c, idx;
      nr   = sb.rows_in_use();
      nc   = sb.cols_in_use();
      pick = int'($urandom_range(0, 99));
      if (pick < 30) begin
         r = int'($urandom_range(0, nr - 1));
         c = int'($urandom_range(0, nc - 1));
         send_req(OP_WRITE, POS_W'(r), POS_W'(c), cost_for(kind, r, c), IDX_W'($urandom));
      end else if (pick < 52) begin
         r = ($urandom_range(0, 4) == 0) ? -int'($urandom_range(1, 64))
                                         : int'($urandom_range(0, nr - 1));
         c = ($urandom_range(0, 4) == 0) ? -int'($urandom_range(1, 64))
                                         : int'($urandom_range(0, nc - 1));
         send_req(OP_TRACE, POS_W'(r), POS_W'(c), COST_BITS'($urandom), IDX_W'($urandom));
      end else if (pick < 85) begin
         idx = (sb.path_len > 0) ? int'($urandom_range(0, sb.path_len - 1))
                                 : int'($urandom_range(0, 126));
         send_req(OP_READ, POS_W'($urandom), POS_W'($urandom), COST_BITS'($urandom),
                  IDX_W'(idx));
      end else begin
         case ($urandom_range(0, 3))
            0: send_req(OP_WRITE, POS_W'($urandom), POS_W'($urandom), COST_BITS'($urandom),
                        IDX_W'($urandom));
            1: send_req(OP_TRACE, POS_W'($urandom), POS_W'($urandom), COST_BITS'($urandom),
                        IDX_W'($urandom));
            2: begin
               idx = (sb.path_len <= 126) ? int'($urandom_range(sb.path_len, 126))
                                          : int'($urandom_range(0, 126));
               send_req(OP_READ, POS_W'($urandom), POS_W'($urandom), COST_BITS'($urandom),
                        IDX_W'(idx));
            end
            default: send_req(OP_UNUSED, POS_W'($urandom), POS_W'($urandom),
                              COST_BITS'($urandom), IDX_W'($urandom));
         endcase
      end
   endtask

   task automatic run_phase(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                            fill_kind_type kind, bit refill, bit squeeze, int count);
      int n;
      set_dims(rows, cols);
      if (refill) fill_rect(kind, 0);
      for (n = 0; n < count; n++) begin
         if (squeeze && n == 5) hold_toggle <= ~hold_toggle;
         // sender waits for every response once per phase
         if (n == count / 2) wait_drain();
         random_item(kind);
         random_total++;
      end
   endtask

   initial begin
      int rows, cols;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_dims(CFG_W'(MAX_DIM), CFG_W'(MAX_DIM));

      // nothing here reads a cost entry: empty path, edge walks, rejects
      send_req(OP_READ, '0, '0, '0, '0);
      send_req(OP_UNUSED, '1, '1, '1, '1);
      send_req(OP_WRITE, '1, '0, '1, '0);
      send_req(OP_WRITE, '0, POS_W'(-64), '0, '0);
      send_req(OP_TRACE, '0, '0, '0, '0);
      send_req(OP_READ, '0, '0, '0, '0);
      send_req(OP_READ, '0, '0, '0, IDX_W'(1));
      send_req(OP_TRACE, '0, '1, '0, '0);
      send_req(OP_READ, '0, '0, '0, IDX_W'(63));
      send_req(OP_TRACE, '1, '0, '0, '0);
      send_req(OP_READ, '0, '0, '0, IDX_W'(63));
      send_req(OP_READ, '0, '0, '0, IDX_W'(64));

      // the walks below only read the last two rows
      fill_rect(FILL_SKEW, MAX_DIM - 2);
      // longest path: along the last row, then up column 0
      send_req(OP_TRACE, '1, '1, '0, '0);
      send_req(OP_READ, '0, '0, '0, IDX_W'(126));
      send_req(OP_READ, '0, '0, '0, IDX_W'(64));
      send_req(OP_READ, '0, '0, '0, '0);
      send_req(OP_WRITE, '0, '0, '0, '0);
      send_req(OP_WRITE, POS_W'(63), POS_W'(63), '1, '0);
      send_req(OP_TRACE, POS_W'(63), POS_W'(62), '0, '0);
      send_req(OP_READ, '0, '0, '0, IDX_W'(1));

      run_phase(CFG_W'(1), CFG_W'(64), FILL_RANDOM, 1'b1, 1'b1, 60);
      send_req(OP_TRACE, POS_W'(1), '1, '0, '0);
      send_req(OP_WRITE, POS_W'(1), '0, '0, '0);
      run_phase(CFG_W'(64), CFG_W'(1), FILL_TIES, 1'b1, 1'b0, 60);
      send_req(OP_TRACE, '1, POS_W'(1), '0, '0);
      // register values outside 1..64 clamp
      run_phase(CFG_W'(0), CFG_W'(100), FILL_TIES, 1'b1, 1'b0, 40);
      run_phase(CFG_W'(127), CFG_W'(0), FILL_RANDOM, 1'b1, 1'b0, 40);

      while (random_total < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            rows = int'($urandom_range(1, 64));
            cols = int'($urandom_range(1, 4));
            if ($urandom_range(0, 1) == 1) begin
               cols = rows;
               rows = int'($urandom_range(1, 4));
            end
         end else begin
            rows = int'($urandom_range(2, 8));
            cols = int'($urandom_range(2, 8));
         end
         run_phase(CFG_W'(rows), CFG_W'(cols), fill_kind_type'($urandom_range(0, 2)),
                   1'b1, 1'b0, 60);
      end

      wait_drain();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
